[hdl/fdda_pkg.sv]
// ----------------------------------------------------------------------------
// fdda_pkg
// Types, constants and microcode for the fixed-point DDA line pixel unit.
// ----------------------------------------------------------------------------
package fdda_pkg;

  localparam int COORD_BITS  = 11;
  localparam int FRAC_BITS   = 10;
  localparam int ACC_BITS    = 24;
  localparam int STEP_BITS   = 12;
  localparam int LEN_BITS    = COORD_BITS + 1;
  localparam int NUM_BITS    = COORD_BITS + 1 + FRAC_BITS;
  localparam int CNT_BITS    = $clog2(NUM_BITS);
  localparam int POS_BITS    = ACC_BITS - FRAC_BITS;
  localparam int ADDR_BITS   = 23;
  localparam int COLOR_BITS  = 24;
  localparam int STRIDE_BITS = 13;
  localparam int DATA_BITS   = 32;
  localparam int PADDR_BITS  = 3;

  localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 13'd640;

  // register index, taken from paddr[2]
  localparam logic REG_ROW_STRIDE = 1'b0;

  // func codes
  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  // sequencer
  localparam int UPC_BITS = 2;
  typedef logic [UPC_BITS-1:0] upc_t;
  localparam upc_t UPC_IDLE   = 2'd0;
  localparam upc_t UPC_SETUP  = 2'd1;
  localparam upc_t UPC_DIV    = 2'd2;
  localparam upc_t UPC_FINISH = 2'd3;
  localparam int ROM_DEPTH = 4;

  typedef enum logic [1:0] {
    OP_WAIT,
    OP_SETUP,
    OP_DIV,
    OP_FINISH
  } uop_t;

  typedef enum logic [1:0] {
    JMP_NEVER,
    JMP_NO_START,
    JMP_DIV_MORE,
    JMP_ALWAYS
  } jcond_t;

  typedef struct packed {
    uop_t   op;
    jcond_t cond;
    upc_t   target;
  } ctrl_word_t;

  // jump taken -> target, else fall through to the next step
  localparam ctrl_word_t UCODE [ROM_DEPTH] = '{
    '{op: OP_WAIT,   cond: JMP_NO_START, target: UPC_IDLE},
    '{op: OP_SETUP,  cond: JMP_NEVER,    target: UPC_IDLE},
    '{op: OP_DIV,    cond: JMP_DIV_MORE, target: UPC_DIV},
    '{op: OP_FINISH, cond: JMP_ALWAYS,   target: UPC_IDLE}
  };

endpackage

[hdl/fdda_if.sv]
// ----------------------------------------------------------------------------
// fdda_if
// Valid/ready channels for line commands and generated pixels.
// ----------------------------------------------------------------------------
interface fdda_cmd_if;
  import fdda_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic [COLOR_BITS-1:0] line_color;

  modport source (output valid, func, start_x, start_y, end_x, end_y, line_color,
                  input ready);
  modport sink (input valid, func, start_x, start_y, end_x, end_y, line_color,
                output ready);
endinterface

interface fdda_pix_if;
  import fdda_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ADDR_BITS-1:0]  pixel_address;
  logic [COLOR_BITS-1:0] pixel_color;
  logic                  is_last;

  modport source (output valid, pixel_address, pixel_color, is_last, input ready);
  modport sink (input valid, pixel_address, pixel_color, is_last, output ready);
endinterface

[hdl/fixed_point_dda_line_pixels_unit.sv]
// ----------------------------------------------------------------------------
// fixed_point_dda_line_pixels_unit
// DDA line pixel generator, 10 fraction bits, microcoded start sequence.
// ----------------------------------------------------------------------------
// channel | dir | transaction
// cmd     | in  | func, start_x, start_y, end_x, end_y, line_color
// pix     | out | pixel_address, pixel_color, is_last
// apb     | cfg | row_stride at byte address 0
//
// Advance: one pixel per clock while pix is taken.
// Start: setup, 22 restoring divide steps of the divider, then finish, before
// the next command is accepted.
// Reset: row_stride = 640, no line active, pixel register empty.
// Commands stall while a pixel waits in the output register and is not taken.
// ----------------------------------------------------------------------------
module fixed_point_dda_line_pixels_unit (
  input  logic                            clk,
  input  logic                            rst,
  fdda_cmd_if.sink                        cmd,
  fdda_pix_if.source                      pix,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fdda_pkg::PADDR_BITS-1:0] paddr,
  input  logic [fdda_pkg::DATA_BITS-1:0]  pwdata,
  output logic [fdda_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready
);
  import fdda_pkg::*;

  localparam logic signed [STEP_BITS-1:0] ONE = STEP_BITS'(1) <<< FRAC_BITS;

  upc_t       upc;
  upc_t       upc_next;
  ctrl_word_t cw;
  logic       jump;

  logic [STRIDE_BITS-1:0] row_stride;

  logic signed [ACC_BITS-1:0]  x_accum;
  logic signed [ACC_BITS-1:0]  y_accum;
  logic signed [STEP_BITS-1:0] x_increment;
  logic signed [STEP_BITS-1:0] y_increment;
  logic [LEN_BITS-1:0]         pixels_left;
  logic [COLOR_BITS-1:0]       held_color;

  logic [COORD_BITS-1:0] sx, sy, ex, ey;
  logic [LEN_BITS-1:0]   len;
  logic [NUM_BITS-1:0]   quo;
  logic [LEN_BITS-1:0]   rem;
  logic [CNT_BITS-1:0]   cnt;
  logic                  x_major, major_neg, minor_neg;

  logic start_acc, adv_acc, emit;

  // setup datapath
  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS:0]        adx_w, ady_w;
  logic [COORD_BITS-1:0]      adx, ady, major_mag, minor_mag;
  logic                       x_major_c;

  // divider step
  logic [LEN_BITS:0] trial;

  // finish datapath
  logic signed [STEP_BITS-1:0] q, minor_step, major_step;

  // pixel datapath
  logic signed [POS_BITS-1:0]           row, col;
  logic signed [POS_BITS+STRIDE_BITS:0] prod;
  logic [ADDR_BITS-1:0]                 addr;

  assign cw = UCODE[upc];

  assign cmd.ready = (cw.op == OP_WAIT) && (!pix.valid || pix.ready);
  assign start_acc = cmd.valid && cmd.ready && (cmd.func == FUNC_START);
  assign adv_acc   = cmd.valid && cmd.ready && (cmd.func == FUNC_ADVANCE);
  assign emit      = adv_acc && (pixels_left != '0);

  always_comb begin
    unique case (cw.cond)
      JMP_NEVER:    jump = 1'b0;
      JMP_NO_START: jump = !start_acc;
      JMP_DIV_MORE: jump = (cnt != '0);
      JMP_ALWAYS:   jump = 1'b1;
      default:      jump = 1'b0;
    endcase
    upc_next = jump ? cw.target : upc_t'(upc + 1'b1);
  end

  always_comb begin
    dx        = $signed({1'b0, ex}) - $signed({1'b0, sx});
    dy        = $signed({1'b0, ey}) - $signed({1'b0, sy});
    adx_w     = dx[COORD_BITS] ? -dx : dx;
    ady_w     = dy[COORD_BITS] ? -dy : dy;
    adx       = adx_w[COORD_BITS-1:0];
    ady       = ady_w[COORD_BITS-1:0];
    x_major_c = (adx >= ady);
    major_mag = x_major_c ? adx : ady;
    minor_mag = x_major_c ? ady : adx;
  end

  assign trial = {rem, quo[NUM_BITS-1]} - {1'b0, len};

  always_comb begin
    q          = $signed(quo[STEP_BITS-1:0]);
    minor_step = minor_neg ? -q : q;
    major_step = major_neg ? -ONE : ONE;
  end

  always_comb begin
    row  = $signed(y_accum[ACC_BITS-1:FRAC_BITS]);
    col  = $signed(x_accum[ACC_BITS-1:FRAC_BITS]);
    prod = row * $signed({1'b0, row_stride});
    addr = prod[ADDR_BITS-1:0] + ADDR_BITS'(col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UPC_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_stride <= STRIDE_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_ROW_STRIDE)) begin
      row_stride <= pwdata[STRIDE_BITS-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ROW_STRIDE) ?
                  DATA_BITS'(row_stride) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_accum     <= '0;
      y_accum     <= '0;
      x_increment <= '0;
      y_increment <= '0;
      pixels_left <= '0;
      held_color  <= '0;
    end else begin
      case (cw.op)
        OP_WAIT: begin
          if (start_acc) begin
            x_accum     <= ACC_BITS'(cmd.start_x) <<< FRAC_BITS;
            y_accum     <= ACC_BITS'(cmd.start_y) <<< FRAC_BITS;
            held_color  <= cmd.line_color;
            pixels_left <= '0;
          end else if (emit) begin
            x_accum     <= x_accum + ACC_BITS'(x_increment);
            y_accum     <= y_accum + ACC_BITS'(y_increment);
            pixels_left <= pixels_left - 1'b1;
          end
        end
        OP_FINISH: begin
          pixels_left <= len;
          x_increment <= x_major ? major_step : minor_step;
          y_increment <= x_major ? minor_step : major_step;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cw.op)
      OP_WAIT: begin
        if (start_acc) begin
          sx <= cmd.start_x;
          sy <= cmd.start_y;
          ex <= cmd.end_x;
          ey <= cmd.end_y;
        end
      end
      OP_SETUP: begin
        x_major   <= x_major_c;
        major_neg <= x_major_c ? dx[COORD_BITS] : dy[COORD_BITS];
        minor_neg <= x_major_c ? dy[COORD_BITS] : dx[COORD_BITS];
        len       <= LEN_BITS'(major_mag) + 1'b1;
        quo       <= (NUM_BITS'(minor_mag) + 1'b1) << FRAC_BITS;
        rem       <= '0;
        cnt       <= CNT_BITS'(NUM_BITS - 1);
      end
      OP_DIV: begin
        cnt <= cnt - 1'b1;
        if (!trial[LEN_BITS]) begin
          rem <= trial[LEN_BITS-1:0];
          quo <= {quo[NUM_BITS-2:0], 1'b1};
        end else begin
          rem <= {rem[LEN_BITS-2:0], quo[NUM_BITS-1]};
          quo <= {quo[NUM_BITS-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else if (emit) begin
      pix.valid <= 1'b1;
    end else if (pix.ready) begin
      pix.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pix.pixel_address <= addr;
      pix.pixel_color   <= held_color;
      pix.is_last       <= (pixels_left == LEN_BITS'(1));
    end
  end

  a_start_runs_setup: assert property (@(posedge clk) disable iff (rst)
    start_acc |=> (upc == UPC_SETUP))
    else $error("start transaction did not enter setup");

  a_busy_blocks_cmd: assert property (@(posedge clk) disable iff (rst)
    (upc != UPC_IDLE) |-> !cmd.ready)
    else $error("command accepted during start sequence");

  a_emit_counts: assert property (@(posedge clk) disable iff (rst)
    emit |=> (pixels_left == $past(pixels_left) - 1'b1) && pix.valid)
    else $error("pixel emission did not consume one pixel");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    (emit && (pixels_left == LEN_BITS'(1))) |=> pix.is_last && (pixels_left == '0))
    else $error("last pixel not flagged");

  a_major_unit: assert property (@(posedge clk) disable iff (rst)
    (upc == UPC_FINISH) |=> (x_increment == ONE || x_increment == -ONE ||
                             y_increment == ONE || y_increment == -ONE))
    else $error("major axis step is not one pixel");

endmodule
